// File: hdl/bwb_pkg.sv
// ----------------------------------------------------------------------------
// bwb_pkg
// Shared types and constants for the Bayer white-balance gain stage.
// ----------------------------------------------------------------------------
package bwb_pkg;

  localparam int CT_POINTS  = 4;
  localparam int BR_POINTS  = 4;
  localparam int CT_IW      = $clog2(CT_POINTS);
  localparam int BR_IW      = $clog2(BR_POINTS);
  localparam int TBL_DEPTH  = CT_POINTS * BR_POINTS;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int DIV_W      = 44;
  localparam int DIVS_W     = 32;
  localparam int DIV_CW     = $clog2(DIV_W + 1);
  localparam int CT_W       = 23;

  localparam logic [2:0] OP_CT_WR  = 3'd0;
  localparam logic [2:0] OP_BR_WR  = 3'd1;
  localparam logic [2:0] OP_TBL_WR = 3'd2;
  localparam logic [2:0] OP_SETUP  = 3'd3;
  localparam logic [2:0] OP_PIXEL  = 3'd4;

  localparam logic [15:0] UNITY_GAIN = 16'd128;
  localparam logic [9:0]  PIX_MAX    = 10'd1023;
  localparam logic [13:0] DIM_MAX    = 14'd8192;

  localparam int         CFG_AW     = 1;
  localparam int         CFG_DW     = 14;
  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;
  localparam logic [13:0] WIDTH_RST  = 14'd1920;
  localparam logic [13:0] HEIGHT_RST = 14'd1080;

  // data: writes use [31:0]; setup {b, g, r, exposure, sensor gain}; pixel [15:0]
  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  idx;
    logic [1:0]  color;
    logic [79:0] data;
  } bwb_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVS_W-1:0] divisor;
  } bwb_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } bwb_div_rsp_t;

endpackage

// File: hdl/bwb_front.sv
// ----------------------------------------------------------------------------
// bwb_front
// Input decode: unpacks a transfer, drops unused ops and out-of-range writes.
// ----------------------------------------------------------------------------
module bwb_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        in_tuser,   // op
  input  logic [135:0]      in_tdata,   // index, color, write_value, sensor_gain,
                                        // exposure, awb_r, awb_g, awb_b, pixel_in
  input  logic              q_full,
  output logic              q_push,
  output bwb_pkg::bwb_item_t q_item
);

  logic keep;

  always_comb begin
    q_item.op    = in_tuser;
    q_item.idx   = in_tdata[5:0];
    q_item.color = in_tdata[7:6];
    q_item.data  = '0;
    keep         = 1'b0;
    case (in_tuser)
      bwb_pkg::OP_CT_WR: begin
        keep = (int'(in_tdata[5:0]) < bwb_pkg::CT_POINTS);
        q_item.data[31:0] = in_tdata[39:8];
      end
      bwb_pkg::OP_BR_WR: begin
        keep = (int'(in_tdata[5:0]) < bwb_pkg::BR_POINTS);
        q_item.data[31:0] = in_tdata[39:8];
      end
      bwb_pkg::OP_TBL_WR: begin
        keep = (int'(in_tdata[5:0]) < bwb_pkg::TBL_DEPTH) && (in_tdata[7:6] != 2'd3);
        q_item.data[31:0] = in_tdata[39:8];
      end
      bwb_pkg::OP_SETUP: begin
        keep = 1'b1;
        q_item.data = in_tdata[119:40];
      end
      bwb_pkg::OP_PIXEL: begin
        keep = 1'b1;
        q_item.data[15:0] = in_tdata[135:120];
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && keep;

endmodule

// File: hdl/bwb_fifo.sv
// ----------------------------------------------------------------------------
// bwb_fifo
// Short queue of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module bwb_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bwb_pkg::bwb_item_t din,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output bwb_pkg::bwb_item_t dout
);

  bwb_pkg::bwb_item_t              mem_r [bwb_pkg::FIFO_DEPTH];
  logic [bwb_pkg::FIFO_AW-1:0]     wr_ptr_r;
  logic [bwb_pkg::FIFO_AW-1:0]     rd_ptr_r;
  logic [bwb_pkg::FIFO_AW:0]       cnt_r;

  assign full  = (cnt_r == (bwb_pkg::FIFO_AW+1)'(bwb_pkg::FIFO_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= din;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: hdl/bwb_div.sv
// ----------------------------------------------------------------------------
// bwb_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bwb_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bwb_pkg::bwb_div_req_t req,
  output bwb_pkg::bwb_div_rsp_t rsp
);

  logic [bwb_pkg::DIV_W-1:0]  dvd_r;
  logic [bwb_pkg::DIVS_W-1:0] dvs_r;
  logic [bwb_pkg::DIVS_W-1:0] rem_r;
  logic [bwb_pkg::DIV_CW-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [bwb_pkg::DIVS_W:0]   sh;
  logic                       qbit;
  logic [bwb_pkg::DIVS_W-1:0] rem_nxt;

  always_comb begin
    sh      = {rem_r, dvd_r[bwb_pkg::DIV_W-1]};
    qbit    = (sh >= {1'b0, dvs_r});
    rem_nxt = qbit ? bwb_pkg::DIVS_W'(sh - {1'b0, dvs_r}) : sh[bwb_pkg::DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= bwb_pkg::DIV_CW'(bwb_pkg::DIV_W);
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[bwb_pkg::DIV_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == bwb_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

// File: hdl/bwb_back.sv
// ----------------------------------------------------------------------------
// bwb_back
// Execution: table writes, frame-setup sequencer, pixel gain and output stage.
// ----------------------------------------------------------------------------
module bwb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  bwb_pkg::bwb_item_t                q_item,
  output logic                              q_pop,
  input  logic                              cfg_we,
  input  logic [bwb_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [bwb_pkg::CFG_DW-1:0]        cfg_wdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [63:0]                       out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_BRIGHT = 4'd1;
  localparam logic [3:0] ST_CTDIV  = 4'd2;
  localparam logic [3:0] ST_CTWAIT = 4'd3;
  localparam logic [3:0] ST_CTSEG  = 4'd4;
  localparam logic [3:0] ST_RDA    = 4'd5;
  localparam logic [3:0] ST_RDB    = 4'd6;
  localparam logic [3:0] ST_RDC    = 4'd7;
  localparam logic [3:0] ST_LMUL   = 4'd8;
  localparam logic [3:0] ST_LDIV   = 4'd9;
  localparam logic [3:0] ST_LWAIT  = 4'd10;
  localparam logic [3:0] ST_GMUL   = 4'd11;
  localparam logic [3:0] ST_MIN    = 4'd12;
  localparam logic [3:0] ST_NDIV   = 4'd13;
  localparam logic [3:0] ST_NWAIT  = 4'd14;
  localparam logic [3:0] ST_DONE   = 4'd15;

  localparam int CI = bwb_pkg::CT_IW;
  localparam int BI = bwb_pkg::BR_IW;
  localparam int TA = bwb_pkg::TBL_AW;

  logic [3:0]  st_r;
  logic [1:0]  ch_r;
  logic        jj_r;
  logic        ph_r;

  logic [13:0] width_r, height_r;
  logic [12:0] col_cnt_r, row_cnt_r;
  logic [15:0] ag_r  [3];
  logic [15:0] agn_r [3];

  logic [15:0] ctp_r [bwb_pkg::CT_POINTS];
  logic [31:0] bp_r  [bwb_pkg::BR_POINTS];
  logic [11:0] tbl_mem [3][bwb_pkg::TBL_DEPTH];
  logic [11:0] rd_r  [3];

  logic [15:0] sg_r, ex_r;
  logic [15:0] gn_r [3];
  logic [31:0] bright_r;
  logic [bwb_pkg::CT_W-1:0] ct_r;
  logic        br_lerp_r, ct_lerp_r;
  logic [BI-1:0] brsel_r;
  logic [CI-1:0] col0_r, col1_r;
  logic [31:0] br_x0_r, br_x1_r;
  logic [15:0] ct_x0_r, ct_x1_r;
  logic [11:0] ya_r [3];
  logic [11:0] yb_r [3];
  logic [11:0] cv_r [2][3];
  logic [11:0] sh_r [3];
  logic [43:0] prod_r;
  logic [31:0] den_r;
  logic        neg_r;
  logic [20:0] g_r [3];
  logic [20:0] mn_r;

  logic        out_valid_r, okind_r, ofend_r;
  logic [9:0]  opix_r;
  logic [15:0] og_r [3];

  bwb_pkg::bwb_div_req_t div_req;
  bwb_pkg::bwb_div_rsp_t div_rsp;

  logic        slot_free, idle_pop, pix_load, rep_load;
  logic [13:0] w_eff, h_eff;
  logic        col_wrap, row_wrap, fend_c;
  logic [15:0] psel;
  logic [31:0] pprod;
  logic [9:0]  pval;

  logic          br_hit, br_lerp;
  logic [BI-1:0] br_i, br_k;
  logic [31:0]   br_x0, br_x1;
  logic          ct_hit, ct_lerp;
  logic [CI-1:0] ct_i, ct_k;
  logic [15:0]   ct_x0, ct_x1;

  logic [CI-1:0] colcur;
  logic [TA-1:0] rd_addr;

  logic [31:0] lx0, lx1, lx, ldx, lden;
  logic [11:0] ly0, ly1, lmag, lq, lval;
  logic        lplain, lneg, lstore;
  logic [43:0] lprod;
  logic [27:0] gprod;
  logic [20:0] mn_c;
  logic [15:0] nsat;

  bwb_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // handshake and pixel path
  always_comb begin
    slot_free = !out_valid_r || out_tready;
    idle_pop  = (st_r == ST_IDLE) && q_valid &&
                ((q_item.op != bwb_pkg::OP_PIXEL) || slot_free);
    pix_load  = idle_pop && (q_item.op == bwb_pkg::OP_PIXEL);
    rep_load  = (st_r == ST_DONE) && slot_free;
    q_pop     = idle_pop;

    w_eff = (width_r == '0) ? 14'd1 : ((width_r > bwb_pkg::DIM_MAX) ? bwb_pkg::DIM_MAX : width_r);
    h_eff = (height_r == '0) ? 14'd1 :
            ((height_r > bwb_pkg::DIM_MAX) ? bwb_pkg::DIM_MAX : height_r);
    col_wrap = ({1'b0, col_cnt_r} + 14'd1) >= w_eff;
    row_wrap = ({1'b0, row_cnt_r} + 14'd1) >= h_eff;
    fend_c   = col_wrap && row_wrap;

    if (!row_cnt_r[0] && !col_cnt_r[0]) psel = ag_r[0];
    else if (row_cnt_r[0] && col_cnt_r[0]) psel = ag_r[2];
    else psel = ag_r[1];
    pprod = 32'(q_item.data[15:0]) * 32'(psel);
    pval  = (|pprod[31:17]) ? bwb_pkg::PIX_MAX : pprod[16:7];
  end

  // segment search: last matching segment, then the end clamps
  always_comb begin
    br_hit = 1'b0;
    br_i   = '0;
    br_x0  = bp_r[0];
    br_x1  = bp_r[0];
    for (int i = 0; i < bwb_pkg::BR_POINTS - 1; i++) begin
      if (bright_r >= bp_r[i] && bright_r < bp_r[i+1]) begin
        br_hit = 1'b1;
        br_i   = BI'(i);
        br_x0  = bp_r[i];
        br_x1  = bp_r[i+1];
      end
    end
    br_lerp = br_hit;
    br_k    = '0;
    if (bright_r < bp_r[0]) br_lerp = 1'b0;
    if (bright_r >= bp_r[bwb_pkg::BR_POINTS-1]) begin
      br_lerp = 1'b0;
      br_k    = BI'(bwb_pkg::BR_POINTS - 1);
    end

    ct_hit = 1'b0;
    ct_i   = '0;
    ct_x0  = ctp_r[0];
    ct_x1  = ctp_r[0];
    for (int i = 0; i < bwb_pkg::CT_POINTS - 1; i++) begin
      if (ct_r >= bwb_pkg::CT_W'(ctp_r[i]) && ct_r < bwb_pkg::CT_W'(ctp_r[i+1])) begin
        ct_hit = 1'b1;
        ct_i   = CI'(i);
        ct_x0  = ctp_r[i];
        ct_x1  = ctp_r[i+1];
      end
    end
    ct_lerp = ct_hit;
    ct_k    = '0;
    if (ct_r < bwb_pkg::CT_W'(ctp_r[0])) ct_lerp = 1'b0;
    if (ct_r >= bwb_pkg::CT_W'(ctp_r[bwb_pkg::CT_POINTS-1])) begin
      ct_lerp = 1'b0;
      ct_k    = CI'(bwb_pkg::CT_POINTS - 1);
    end
  end

  // interpolation and gain arithmetic
  always_comb begin
    colcur  = jj_r ? col1_r : col0_r;
    rd_addr = TA'(int'(colcur) * bwb_pkg::BR_POINTS + int'(brsel_r)) +
              TA'((st_r == ST_RDB) && br_lerp_r);

    lx0    = ph_r ? {16'b0, ct_x0_r} : br_x0_r;
    lx1    = ph_r ? {16'b0, ct_x1_r} : br_x1_r;
    lx     = ph_r ? 32'(ct_r) : bright_r;
    ly0    = ph_r ? cv_r[0][ch_r] : ya_r[ch_r];
    ly1    = ph_r ? cv_r[1][ch_r] : yb_r[ch_r];
    lplain = ph_r ? !ct_lerp_r : !br_lerp_r;
    lneg   = ly1 < ly0;
    lmag   = lneg ? (ly0 - ly1) : (ly1 - ly0);
    ldx    = lx - lx0;
    lden   = lx1 - lx0;
    lprod  = 44'(lmag) * 44'(ldx);
    lq     = div_rsp.quotient[11:0];
    lval   = (st_r == ST_LMUL) ? ly0 : (neg_r ? (ly0 - lq) : (ly0 + lq));
    lstore = ((st_r == ST_LMUL) && lplain) || ((st_r == ST_LWAIT) && div_rsp.done);

    gprod = 28'(gn_r[ch_r]) * 28'(sh_r[ch_r]);
    mn_c  = g_r[0];
    if (g_r[1] < mn_c) mn_c = g_r[1];
    if (g_r[2] < mn_c) mn_c = g_r[2];
    nsat  = (|div_rsp.quotient[bwb_pkg::DIV_W-1:16]) ? 16'hFFFF : div_rsp.quotient[15:0];

    div_req.start    = (st_r == ST_CTDIV) || (st_r == ST_LDIV) || (st_r == ST_NDIV);
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (st_r)
      ST_CTDIV: begin
        div_req.dividend = bwb_pkg::DIV_W'({gn_r[2], 7'b0});
        div_req.divisor  = bwb_pkg::DIVS_W'(gn_r[0]);
      end
      ST_LDIV: begin
        div_req.dividend = prod_r;
        div_req.divisor  = den_r;
      end
      ST_NDIV: begin
        div_req.dividend = bwb_pkg::DIV_W'({g_r[ch_r], 7'b0});
        div_req.divisor  = bwb_pkg::DIVS_W'(mn_r);
      end
      default: ;
    endcase
  end

  // gain-shift table
  always_ff @(posedge clk) begin
    if (idle_pop && (q_item.op == bwb_pkg::OP_TBL_WR)) begin
      tbl_mem[q_item.color][q_item.idx[TA-1:0]] <= q_item.data[11:0];
    end
    for (int c = 0; c < 3; c++) rd_r[c] <= tbl_mem[c][rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ch_r        <= '0;
      jj_r        <= 1'b0;
      ph_r        <= 1'b0;
      width_r     <= bwb_pkg::WIDTH_RST;
      height_r    <= bwb_pkg::HEIGHT_RST;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < 3; c++) ag_r[c] <= bwb_pkg::UNITY_GAIN;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          bwb_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
          bwb_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end

      case (st_r)
        ST_IDLE: begin
          if (idle_pop) begin
            case (q_item.op)
              bwb_pkg::OP_CT_WR: ctp_r[q_item.idx[CI-1:0]] <= q_item.data[15:0];
              bwb_pkg::OP_BR_WR: bp_r[q_item.idx[BI-1:0]]  <= q_item.data[31:0];
              bwb_pkg::OP_SETUP: begin
                sg_r    <= q_item.data[15:0];
                ex_r    <= q_item.data[31:16];
                gn_r[2] <= q_item.data[47:32];
                gn_r[1] <= q_item.data[63:48];
                gn_r[0] <= q_item.data[79:64];
                st_r    <= ST_BRIGHT;
              end
              bwb_pkg::OP_PIXEL: begin
                if (col_wrap) begin
                  col_cnt_r <= '0;
                  row_cnt_r <= row_wrap ? 13'd0 : (row_cnt_r + 13'd1);
                end else begin
                  col_cnt_r <= col_cnt_r + 13'd1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_BRIGHT: begin
          bright_r <= 32'(sg_r) * 32'(ex_r);
          if (gn_r[0] == '0) begin
            for (int c = 0; c < 3; c++) agn_r[c] <= bwb_pkg::UNITY_GAIN;
            st_r <= ST_DONE;
          end else begin
            st_r <= ST_CTDIV;
          end
        end
        ST_CTDIV: begin
          br_lerp_r <= br_lerp;
          brsel_r   <= br_lerp ? br_i : br_k;
          br_x0_r   <= br_x0;
          br_x1_r   <= br_x1;
          st_r      <= ST_CTWAIT;
        end
        ST_CTWAIT: begin
          if (div_rsp.done) begin
            ct_r <= div_rsp.quotient[bwb_pkg::CT_W-1:0];
            st_r <= ST_CTSEG;
          end
        end
        ST_CTSEG: begin
          ct_lerp_r <= ct_lerp;
          col0_r    <= ct_lerp ? ct_i : ct_k;
          col1_r    <= ct_i + 1'b1;
          ct_x0_r   <= ct_x0;
          ct_x1_r   <= ct_x1;
          jj_r      <= 1'b0;
          ph_r      <= 1'b0;
          st_r      <= ST_RDA;
        end
        ST_RDA: st_r <= ST_RDB;
        ST_RDB: begin
          for (int c = 0; c < 3; c++) ya_r[c] <= rd_r[c];
          st_r <= ST_RDC;
        end
        ST_RDC: begin
          for (int c = 0; c < 3; c++) yb_r[c] <= rd_r[c];
          ch_r <= '0;
          st_r <= ST_LMUL;
        end
        ST_LMUL: begin
          prod_r <= lprod;
          den_r  <= lden;
          neg_r  <= lneg;
          if (!lplain) st_r <= ST_LDIV;
        end
        ST_LDIV: st_r <= ST_LWAIT;
        ST_LWAIT: ;
        ST_GMUL: begin
          g_r[ch_r] <= gprod[27:7];
          if (ch_r == 2'd2) begin
            ch_r <= '0;
            st_r <= ST_MIN;
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end
        ST_MIN: begin
          mn_r <= mn_c;
          if (mn_c == '0) begin
            for (int c = 0; c < 3; c++) agn_r[c] <= bwb_pkg::UNITY_GAIN;
            st_r <= ST_DONE;
          end else begin
            st_r <= ST_NDIV;
          end
        end
        ST_NDIV: st_r <= ST_NWAIT;
        ST_NWAIT: begin
          if (div_rsp.done) begin
            agn_r[ch_r] <= nsat;
            if (ch_r == 2'd2) begin
              st_r <= ST_DONE;
            end else begin
              ch_r <= ch_r + 2'd1;
              st_r <= ST_NDIV;
            end
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            for (int c = 0; c < 3; c++) ag_r[c] <= agn_r[c];
            col_cnt_r <= '0;
            row_cnt_r <= '0;
            st_r      <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase

      // a finished channel of either interpolation pass
      if (lstore) begin
        if (ph_r) sh_r[ch_r] <= lval;
        else cv_r[jj_r][ch_r] <= lval;
        if (ch_r != 2'd2) begin
          ch_r <= ch_r + 2'd1;
          st_r <= ST_LMUL;
        end else begin
          ch_r <= '0;
          if (!ph_r && !jj_r && ct_lerp_r) begin
            jj_r <= 1'b1;
            st_r <= ST_RDA;
          end else if (!ph_r) begin
            ph_r <= 1'b1;
            st_r <= ST_LMUL;
          end else begin
            st_r <= ST_GMUL;
          end
        end
      end

      if (pix_load) begin
        out_valid_r <= 1'b1;
        okind_r     <= 1'b1;
        opix_r      <= pval;
        ofend_r     <= fend_c;
        for (int c = 0; c < 3; c++) og_r[c] <= ag_r[c];
      end else if (rep_load) begin
        out_valid_r <= 1'b1;
        okind_r     <= 1'b0;
        opix_r      <= '0;
        ofend_r     <= 1'b0;
        for (int c = 0; c < 3; c++) og_r[c] <= agn_r[c];
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = ofend_r;
  assign out_tdata  = {6'b0, og_r[2], og_r[1], og_r[0], opix_r};

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    pix_load && fend_c |=> col_cnt_r == '0 && row_cnt_r == '0)
    else $error("raster counters not cleared at frame end");

  a_gain_floor: assert property (@(posedge clk) disable iff (!rst_n)
    rep_load |-> agn_r[0] >= bwb_pkg::UNITY_GAIN && agn_r[1] >= bwb_pkg::UNITY_GAIN &&
                 agn_r[2] >= bwb_pkg::UNITY_GAIN)
    else $error("normalised gain below unity");

  a_gain_commit: assert property (@(posedge clk) disable iff (!rst_n)
    rep_load |=> ag_r[0] == $past(agn_r[0]) && ag_r[1] == $past(agn_r[1]) &&
                 ag_r[2] == $past(agn_r[2]))
    else $error("reported gains not committed");

endmodule

// File: hdl/bayer_white_balance_apply_core.sv
// ----------------------------------------------------------------------------
// bayer_white_balance_apply_core
// Bayer white-balance gain stage with a bilinear colour-temperature table.
// ----------------------------------------------------------------------------
// A pixel stream runs at one transfer per clock while the output is not stalled;
// a four-entry queue separates input decode from execution, and the output
// register is reloaded in the cycle its result is taken. A frame-setup item
// holds the execution side until its gains are reported, plus any output stall;
// when the blue gain is zero it skips the divisions and reports unity gains.
// Every division (colour temperature, each interpolated channel, each
// normalised gain) goes through one shared 44-step serial divider, and the
// gain table is read one entry per cycle. Pixels queued behind a setup use
// the new gains.
module bayer_white_balance_apply_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [2:0]                 in_tuser,   // op
  input  logic [135:0]               in_tdata,   // index, color, write_value,
                                                 // sensor_gain, exposure, awb_r_gain,
                                                 // awb_g_gain, awb_b_gain, pixel_in
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [63:0]                out_tdata,  // pixel_out, applied_b_gain,
                                                 // applied_g_gain, applied_r_gain
  output logic                       out_tuser,  // kind
  output logic                       out_tlast,  // frame_end
  input  logic                       cfg_we,
  input  logic [bwb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bwb_pkg::CFG_DW-1:0] cfg_wdata
);

  bwb_pkg::bwb_item_t f_item, q_item;
  logic               q_push, q_full, q_pop, q_valid;

  bwb_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (f_item)
  );

  bwb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_item)
  );

  bwb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: test/bayer_white_balance_apply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bayer_white_balance_apply_checker
// Watches the input, result and register ports of the white-balance stage,
// predicts every gains report and corrected pixel, and compares them in order.
// ----------------------------------------------------------------------------
module bayer_white_balance_apply_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [2:0]                 in_tuser,
  input  logic [135:0]               in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [63:0]                out_tdata,
  input  logic                       out_tuser,
  input  logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [bwb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bwb_pkg::CFG_DW-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         pending,
  output int                         pixels_seen,
  output int                         reports_seen,
  output int                         frames_seen
);

  typedef struct packed {
    logic        kind;
    logic [9:0]  pix;
    logic [15:0] b_gain;
    logic [15:0] g_gain;
    logic [15:0] r_gain;
    logic        fend;
  } wb_result_t;

  wb_result_t   wb_expected[$];
  logic [13:0]  width_reg, height_reg;
  longint       ct_pt[bwb_pkg::CT_POINTS];
  longint       br_pt[bwb_pkg::BR_POINTS];
  longint       shift_tbl[bwb_pkg::TBL_DEPTH][3];
  longint       gains[3];
  longint       col_cnt, row_cnt;

  assign pending = wb_expected.size();

  function automatic longint interp(longint x0, longint x, longint x1, longint y0, longint y1);
    longint den;
    den = x1 - x0;
    if (den <= 0) return y0;
    return y0 + ((y1 - y0) * (x - x0)) / den;
  endfunction

  function automatic longint clamp_dim(logic [13:0] v);
    if (v < 1) return 1;
    if (v > 8192) return 8192;
    return longint'(v);
  endfunction

  task automatic compute_gains(input logic [135:0] d);
    longint bright, rg, gg, bg, ct, mn;
    longint col[bwb_pkg::CT_POINTS][3];
    longint sh[3], g[3];
    bright = longint'(d[55:40]) * longint'(d[71:56]);
    rg = longint'(d[87:72]);
    gg = longint'(d[103:88]);
    bg = longint'(d[119:104]);
    if (bg == 0) begin
      for (int c = 0; c < 3; c++) gains[c] = 128;
      return;
    end
    ct = (128 * rg) / bg;
    for (int j = 0; j < bwb_pkg::CT_POINTS; j++)
      for (int c = 0; c < 3; c++) col[j][c] = shift_tbl[j*bwb_pkg::BR_POINTS][c];
    for (int i = 0; i < bwb_pkg::BR_POINTS-1; i++)
      if (bright >= br_pt[i] && bright < br_pt[i+1])
        for (int j = 0; j < bwb_pkg::CT_POINTS; j++)
          for (int c = 0; c < 3; c++)
            col[j][c] = interp(br_pt[i], bright, br_pt[i+1],
                               shift_tbl[j*bwb_pkg::BR_POINTS+i][c],
                               shift_tbl[j*bwb_pkg::BR_POINTS+i+1][c]);
    if (bright < br_pt[0])
      for (int j = 0; j < bwb_pkg::CT_POINTS; j++)
        for (int c = 0; c < 3; c++) col[j][c] = shift_tbl[j*bwb_pkg::BR_POINTS][c];
    if (bright >= br_pt[bwb_pkg::BR_POINTS-1])
      for (int j = 0; j < bwb_pkg::CT_POINTS; j++)
        for (int c = 0; c < 3; c++)
          col[j][c] = shift_tbl[j*bwb_pkg::BR_POINTS+bwb_pkg::BR_POINTS-1][c];
    for (int c = 0; c < 3; c++) sh[c] = col[0][c];
    for (int i = 0; i < bwb_pkg::CT_POINTS-1; i++)
      if (ct >= ct_pt[i] && ct < ct_pt[i+1])
        for (int c = 0; c < 3; c++)
          sh[c] = interp(ct_pt[i], ct, ct_pt[i+1], col[i][c], col[i+1][c]);
    if (ct < ct_pt[0])
      for (int c = 0; c < 3; c++) sh[c] = col[0][c];
    if (ct >= ct_pt[bwb_pkg::CT_POINTS-1])
      for (int c = 0; c < 3; c++) sh[c] = col[bwb_pkg::CT_POINTS-1][c];
    g[0] = bg * sh[0] / 128;
    g[1] = gg * sh[1] / 128;
    g[2] = rg * sh[2] / 128;
    mn = g[0];
    if (g[1] < mn) mn = g[1];
    if (g[2] < mn) mn = g[2];
    for (int c = 0; c < 3; c++) begin
      if (mn == 0) gains[c] = 128;
      else begin
        gains[c] = g[c] * 128 / mn;
        if (gains[c] > 65535) gains[c] = 65535;
      end
    end
  endtask

  task automatic predict_item(input logic [2:0] op, input logic [135:0] d);
    wb_result_t r;
    longint     idx, clr, val, w, h, gsel, p;
    idx = longint'(d[5:0]);
    clr = longint'(d[7:6]);
    val = longint'(d[39:8]);
    r = '0;
    case (op)
      bwb_pkg::OP_CT_WR:  if (idx < bwb_pkg::CT_POINTS) ct_pt[idx] = val & 64'hFFFF;
      bwb_pkg::OP_BR_WR:  if (idx < bwb_pkg::BR_POINTS) br_pt[idx] = val;
      bwb_pkg::OP_TBL_WR:
        if (idx < bwb_pkg::TBL_DEPTH && clr < 3) shift_tbl[idx][clr] = val & 64'hFFF;
      bwb_pkg::OP_SETUP: begin
        compute_gains(d);
        col_cnt = 0;
        row_cnt = 0;
        r.b_gain = 16'(gains[0]);
        r.g_gain = 16'(gains[1]);
        r.r_gain = 16'(gains[2]);
        wb_expected.push_back(r);
      end
      bwb_pkg::OP_PIXEL: begin
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (!row_cnt[0] && !col_cnt[0]) gsel = gains[0];
        else if (row_cnt[0] && col_cnt[0]) gsel = gains[2];
        else gsel = gains[1];
        p = longint'(d[135:120]) * gsel / 128;
        if (p > 1023) p = 1023;
        if (col_cnt + 1 >= w) begin
          col_cnt = 0;
          if (row_cnt + 1 >= h) begin
            row_cnt = 0;
            r.fend = 1'b1;
          end else begin
            row_cnt = (row_cnt + 1) & 64'h1FFF;
          end
        end else begin
          col_cnt = (col_cnt + 1) & 64'h1FFF;
        end
        r.kind = 1'b1;
        r.pix = 10'(p);
        r.b_gain = 16'(gains[0]);
        r.g_gain = 16'(gains[1]);
        r.r_gain = 16'(gains[2]);
        wb_expected.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    wb_result_t got, want;
    if (!rst_n) begin
      width_reg  <= bwb_pkg::WIDTH_RST;
      height_reg <= bwb_pkg::HEIGHT_RST;
      for (int c = 0; c < 3; c++) gains[c] = 128;
      col_cnt = 0;
      row_cnt = 0;
      mismatches   <= 0;
      pixels_seen  <= 0;
      reports_seen <= 0;
      frames_seen  <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == bwb_pkg::CFG_WIDTH) width_reg <= cfg_wdata;
        else height_reg <= cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[9:0], out_tdata[25:10], out_tdata[41:26],
               out_tdata[57:42], out_tlast};
        if (out_tuser) pixels_seen <= pixels_seen + 1;
        else reports_seen <= reports_seen + 1;
        if (out_tlast) frames_seen <= frames_seen + 1;
        if (wb_expected.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer: %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = wb_expected.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("mismatch: expected %p, got %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
    end
  end
endmodule

// File: test/bayer_white_balance_apply_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bayer_white_balance_apply_core_tb
// Loads the gain tables, runs directed corner items and then random pixel
// streams with frame setups over several image sizes, with random stalls.
// ----------------------------------------------------------------------------
module bayer_white_balance_apply_core_tb;

  localparam int LIMIT = 4000000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [2:0]                 in_tuser = '0;
  logic [135:0]               in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [63:0]                out_tdata;
  logic                       out_tuser;
  logic                       out_tlast;
  logic                       cfg_we = 1'b0;
  logic [bwb_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [bwb_pkg::CFG_DW-1:0] cfg_wdata = '0;
  int                  mismatches, pending, pixels_seen, reports_seen, frames_seen;
  int                  cycles = 0;
  int                  items_sent = 0;
  int                  hold_left = 0;
  logic                no_idle = 1'b0;
  logic                hold_req = 1'b0;
  logic                hold_done = 1'b0;

  bayer_white_balance_apply_core dut (.*);
  bayer_white_balance_apply_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("bayer_white_balance_apply_core_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 21);
    end
  end

  function automatic logic [135:0] rand_bits();
    return {$urandom, $urandom, $urandom, $urandom, 8'($urandom)};
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [135:0] d);
    if (!no_idle && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic table_write(input logic [2:0] op, input int idx, input int clr,
                             input logic [31:0] val);
    logic [135:0] d;
    d = rand_bits();
    d[5:0]  = 6'(idx);
    d[7:6]  = 2'(clr);
    d[39:8] = val;
    send_item(op, d);
  endtask

  task automatic frame_setup(input logic [15:0] sg, input logic [15:0] ex,
                             input logic [15:0] rg, input logic [15:0] gg,
                             input logic [15:0] bg);
    logic [135:0] d;
    d = rand_bits();
    d[55:40]   = sg;
    d[71:56]   = ex;
    d[87:72]   = rg;
    d[103:88]  = gg;
    d[119:104] = bg;
    send_item(bwb_pkg::OP_SETUP, d);
  endtask

  task automatic pixel(input logic [15:0] p);
    logic [135:0] d;
    d = rand_bits();
    d[135:120] = p;
    send_item(bwb_pkg::OP_PIXEL, d);
  endtask

  task automatic load_points(input bit ordered);
    logic [31:0] v;
    for (int i = 0; i < bwb_pkg::CT_POINTS; i++) begin
      v = ordered ? 32'(40 + i * 90 + $urandom_range(60)) : $urandom;
      table_write(bwb_pkg::OP_CT_WR, i, $urandom_range(3), v);
    end
    for (int i = 0; i < bwb_pkg::BR_POINTS; i++) begin
      v = ordered ? (32'(1) << (8 * i + 4)) + $urandom_range(255) : $urandom;
      table_write(bwb_pkg::OP_BR_WR, i, $urandom_range(3), v);
    end
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic set_size(input logic [13:0] w, input logic [13:0] h);
    cfg_we    <= 1'b1;
    cfg_addr  <= bwb_pkg::CFG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= bwb_pkg::CFG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 3) begin
      send_item(3'($urandom_range(7, 5)), rand_bits());
    end else if (r < 4) begin
      table_write(3'($urandom_range(2)), $urandom_range(63, 48), 3, $urandom);
    end else if (r < 8) begin
      table_write(bwb_pkg::OP_TBL_WR, $urandom_range(bwb_pkg::TBL_DEPTH-1),
                  $urandom_range(2), $urandom);
    end else if (r < 9) begin
      load_points($urandom_range(3) != 0);
    end else if (r < 13) begin
      if ($urandom_range(3) == 0)
        frame_setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
      else
        frame_setup(16'($urandom), 16'($urandom), 16'($urandom_range(1023, 32)),
                    16'($urandom_range(1023, 32)), 16'($urandom_range(1023, 32)));
    end else begin
      pixel(($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1023)));
    end
  endtask

  initial begin
    logic [13:0] widths[6];
    logic [13:0] heights[6];
    widths  = '{14'd2, 14'd10, 14'd8192, 14'd2, 14'd0, 14'd16383};
    heights = '{14'd2, 14'd6, 14'd2, 14'd8192, 14'd0, 14'd3};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every table entry so no setup reads an unwritten one
    load_points(1'b1);
    for (int i = 0; i < bwb_pkg::TBL_DEPTH; i++)
      for (int c = 0; c < 3; c++)
        table_write(bwb_pkg::OP_TBL_WR, i, c, $urandom);

    // directed corners at reset image size
    table_write(bwb_pkg::OP_CT_WR, 63, 0, 32'hFFFF_FFFF);
    table_write(bwb_pkg::OP_TBL_WR, 5, 3, 32'hFFFF_FFFF);
    table_write(bwb_pkg::OP_BR_WR, 4, 0, 32'h0);
    send_item(3'd5, rand_bits());
    send_item(3'd7, '1);
    pixel(16'hFFFF);
    frame_setup(16'd100, 16'd100, 16'd128, 16'd128, 16'd0);
    pixel(16'hFFFF);
    frame_setup(16'd0, 16'd0, 16'd0, 16'd128, 16'd128);
    frame_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    pixel(16'd0);
    pixel(16'd1023);
    pixel(16'hFFFF);
    frame_setup(16'd16, 16'd16, 16'd1, 16'd1, 16'hFFFF);
    frame_setup(16'd300, 16'd200, 16'd256, 16'd128, 16'd200);
    for (int i = 0; i < 6; i++) pixel(16'($urandom_range(1023)));

    for (int ph = 0; ph < 6; ph++) begin
      quiesce();
      set_size(widths[ph], heights[ph]);
      no_idle <= (ph == 1);
      if (ph == 2) hold_req <= 1'b1;
      frame_setup(16'($urandom), 16'($urandom), 16'($urandom_range(1023, 32)),
                  16'($urandom_range(1023, 32)), 16'($urandom_range(1023, 32)));
      repeat (210) random_item();
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);

    $display("%0d items sent over six image sizes, with table reloads and stalls;",
             items_sent);
    $display("%0d pixels, %0d gains reports and %0d frame ends checked.",
             pixels_seen, reports_seen, frames_seen);
    if (mismatches == 0) begin
      $display("bayer_white_balance_apply_core_tb: done, clean");
    end else begin
      $display("bayer_white_balance_apply_core_tb: done, errors");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/bwb_pkg.sv
hdl/bwb_front.sv
hdl/bwb_fifo.sv
hdl/bwb_div.sv
hdl/bwb_back.sv
hdl/bayer_white_balance_apply_core.sv
test/bayer_white_balance_apply_checker.sv
test/bayer_white_balance_apply_core_tb.sv
